// File: hdl/linked_deque_engine_assert.svh
// Assertion macros shared by the linked deque engine RTL.
`ifndef LINKED_DEQUE_ENGINE_ASSERT_SVH
`define LINKED_DEQUE_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante (clk and rst of the enclosing module).
`define LDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linked deque engine: check failed");

// Check that cons holds in the cycle after ante.
`define LDE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linked deque engine: check failed");

`endif

// File: hdl/lde_pkg.sv
// Shared codes, widths and controller/datapath link types for the linked deque engine.
`default_nettype none

package lde_pkg;

  localparam int CMD_W    = 3;
  localparam int WORD_W   = 32;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             bad_handle;
    logic             single;
    logic             at_head;
    logic             at_tail;
    logic             rsp_free;
  } dp_stat_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic                load_item;
    logic                start_read;
    logic                do_push;
    logic                do_clear;
    logic                status_load;
    logic [STATUS_W-1:0] status_code;
    logic                unlink;
    logic                unlink_single;
    logic                unlink_head;
    logic                unlink_tail;
    logic                unlink_mid;
    logic                fetch_head;
    logic                fetch_tail;
    logic                emit;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// File: hdl/lde_cmd_if.sv
// Command channel of the linked deque engine.
`default_nettype none

interface lde_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [lde_pkg::CMD_W-1:0]    command;
  logic [lde_pkg::WORD_W-1:0]   data_word;
  logic [lde_pkg::HANDLE_W-1:0] slot_handle;

  modport source (output valid, command, data_word, slot_handle, input ready);
  modport sink   (input valid, command, data_word, slot_handle, output ready);
endinterface

`default_nettype wire

// File: hdl/lde_rsp_if.sv
// Result channel of the linked deque engine.
`default_nettype none

interface lde_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lde_pkg::STATUS_W-1:0] status;
  logic [lde_pkg::WORD_W-1:0]   out_word;
  logic [lde_pkg::HANDLE_W-1:0] out_slot;
  logic [lde_pkg::COUNT_W-1:0]  entry_count;
  logic [lde_pkg::WORD_W-1:0]   head_word;
  logic [lde_pkg::WORD_W-1:0]   tail_word;

  modport source (output valid, status, out_word, out_slot, entry_count, head_word,
                  tail_word, input ready);
  modport sink   (input valid, status, out_word, out_slot, entry_count, head_word,
                  tail_word, output ready);
endinterface

`default_nettype wire

// File: hdl/lde_free_find.sv
// Lowest free slot finder: binary tree over the in-use bitmap, result registered.
`default_nettype none

module lde_free_find #(
  parameter int NODE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [NODE_DEPTH-1:0]         in_use,
  output logic                          free_any,
  output logic [$clog2(NODE_DEPTH)-1:0] free_slot
);

  localparam int AW    = $clog2(NODE_DEPTH);
  localparam int LEAFS = 1 << AW;
  localparam int NODES = 2 * LEAFS - 1;

  logic          node_v [NODES];
  logic [AW-1:0] node_i [NODES];

  for (genvar i = 0; i < LEAFS; i++) begin : g_leaf
    if (i < NODE_DEPTH) begin : g_real
      assign node_v[LEAFS-1+i] = ~in_use[i];
    end else begin : g_pad
      assign node_v[LEAFS-1+i] = 1'b0;
    end
    assign node_i[LEAFS-1+i] = AW'(i);
  end

  // Prefer the left (lower) child.
  for (genvar n = 0; n < LEAFS - 1; n++) begin : g_node
    assign node_v[n] = node_v[2*n+1] | node_v[2*n+2];
    assign node_i[n] = node_v[2*n+1] ? node_i[2*n+1] : node_i[2*n+2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_any <= 1'b0;
    end else begin
      free_any <= node_v[0];
    end
    free_slot <= node_i[0];
  end

endmodule

`default_nettype wire

// File: hdl/lde_ctrl.sv
// Command sequencer of the linked deque engine.
`default_nettype none

module lde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  lde_pkg::dp_stat_t stat,
  output lde_pkg::ctl_cmd_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       side_head;
  logic       side_head_next;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    side_head_next = side_head;
    cmd_ready      = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.status_load = 1'b1;
        ctl.status_code = lde_pkg::ST_OK;
        state_next      = S_DONE;
        case (stat.cmd)
          lde_pkg::CMD_PUSH_TAIL, lde_pkg::CMD_PUSH_HEAD: begin
            if (stat.full) ctl.status_code = lde_pkg::ST_FULL;
            else ctl.do_push = 1'b1;
          end
          lde_pkg::CMD_POP_TAIL, lde_pkg::CMD_POP_HEAD: begin
            if (stat.empty) begin
              ctl.status_code = lde_pkg::ST_EMPTY;
            end else begin
              ctl.start_read = 1'b1;
              state_next     = S_LINK;
            end
          end
          lde_pkg::CMD_REMOVE: begin
            if (stat.bad_handle) begin
              ctl.status_code = lde_pkg::ST_BAD;
            end else begin
              ctl.start_read = 1'b1;
              state_next     = S_LINK;
            end
          end
          lde_pkg::CMD_CLEAR: ctl.do_clear = 1'b1;
          default: ;
        endcase
      end
      S_LINK: begin
        ctl.unlink = 1'b1;
        if (stat.single) begin
          ctl.unlink_single = 1'b1;
          state_next        = S_DONE;
        end else if (stat.at_head) begin
          ctl.unlink_head = 1'b1;
          side_head_next  = 1'b1;
          state_next      = S_FETCH;
        end else if (stat.at_tail) begin
          ctl.unlink_tail = 1'b1;
          side_head_next  = 1'b0;
          state_next      = S_FETCH;
        end else begin
          ctl.unlink_mid = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_FETCH: begin
        ctl.fetch_head = side_head;
        ctl.fetch_tail = ~side_head;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.rsp_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side_head <= 1'b0;
    end else begin
      state     <= state_next;
      side_head <= side_head_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lde_datapath.sv
// Node store, list registers and result register of the linked deque engine.
`default_nettype none

module lde_datapath #(
  parameter int NODE_DEPTH = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lde_pkg::ctl_cmd_t            ctl,
  output lde_pkg::dp_stat_t            stat,
  input  logic [lde_pkg::CMD_W-1:0]    command,
  input  logic [lde_pkg::WORD_W-1:0]   data_word,
  input  logic [lde_pkg::HANDLE_W-1:0] slot_handle,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output logic [lde_pkg::STATUS_W-1:0] status,
  output logic [lde_pkg::WORD_W-1:0]   out_word,
  output logic [lde_pkg::HANDLE_W-1:0] out_slot,
  output logic [lde_pkg::COUNT_W-1:0]  entry_count,
  output logic [lde_pkg::WORD_W-1:0]   head_word,
  output logic [lde_pkg::WORD_W-1:0]   tail_word
);

  localparam int AW = $clog2(NODE_DEPTH);
  localparam int CW = $clog2(NODE_DEPTH + 1);
  localparam int SW = (WORD_WIDTH < lde_pkg::WORD_W) ? WORD_WIDTH : lde_pkg::WORD_W;

  // Stores: written and read in clocked blocks only.
  logic [SW-1:0] val_mem  [NODE_DEPTH];
  logic [AW-1:0] next_mem [NODE_DEPTH];
  logic [AW-1:0] prev_mem [NODE_DEPTH];

  logic [lde_pkg::CMD_W-1:0]    cmd_q;
  logic [SW-1:0]                word_q;
  logic [lde_pkg::HANDLE_W-1:0] handle_q;
  logic [AW-1:0]                head;
  logic [AW-1:0]                tail;
  logic [CW-1:0]                count;
  logic [SW-1:0]                head_val;
  logic [SW-1:0]                tail_val;
  logic [NODE_DEPTH-1:0]        in_use;
  logic [AW-1:0]                tgt;
  logic [lde_pkg::STATUS_W-1:0] status_q;
  logic [SW-1:0]                oword_q;
  logic [AW-1:0]                oslot_q;
  logic [SW-1:0]                val_rd;
  logic [AW-1:0]                next_rd;
  logic [AW-1:0]                prev_rd;

  logic          free_any;
  logic [AW-1:0] free_slot;
  logic [AW-1:0] tgt_sel;
  logic [AW-1:0] handle_idx;
  logic          handle_in_range;
  logic          list_empty;
  logic [AW-1:0] val_raddr;
  logic          next_we;
  logic [AW-1:0] next_wa;
  logic [AW-1:0] next_wd;
  logic          prev_we;
  logic [AW-1:0] prev_wa;
  logic [AW-1:0] prev_wd;
  logic          push_tail;

  lde_free_find #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_free (
    .clk       (clk),
    .rst       (rst),
    .in_use    (in_use),
    .free_any  (free_any),
    .free_slot (free_slot)
  );

  assign handle_idx      = AW'(handle_q);
  assign handle_in_range = 32'(handle_q) < 32'(NODE_DEPTH);
  assign list_empty      = (count == '0);
  assign push_tail       = (cmd_q == lde_pkg::CMD_PUSH_TAIL);

  always_comb begin
    case (cmd_q)
      lde_pkg::CMD_POP_TAIL: tgt_sel = tail;
      lde_pkg::CMD_POP_HEAD: tgt_sel = head;
      default:               tgt_sel = handle_idx;
    endcase
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.empty      = list_empty;
    stat.full       = ~free_any;
    stat.bad_handle = ~handle_in_range | ~in_use[handle_idx];
    stat.single     = (count <= CW'(1)) | ((tgt == head) & (tgt == tail));
    stat.at_head    = (tgt == head);
    stat.at_tail    = (tgt == tail);
    stat.rsp_free   = ~rsp_valid | rsp_ready;
  end

  // Link writes: a push splices at one end, a middle unlink bridges the neighbours.
  always_comb begin
    next_we = 1'b0;
    next_wa = free_slot;
    next_wd = head;
    prev_we = 1'b0;
    prev_wa = free_slot;
    prev_wd = tail;
    if (ctl.do_push && !list_empty) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (push_tail) begin
        next_wa = tail;
        next_wd = free_slot;
        prev_wa = free_slot;
        prev_wd = tail;
      end else begin
        next_wa = free_slot;
        next_wd = head;
        prev_wa = head;
        prev_wd = free_slot;
      end
    end else if (ctl.unlink_mid) begin
      next_we = 1'b1;
      next_wa = prev_rd;
      next_wd = next_rd;
      prev_we = 1'b1;
      prev_wa = next_rd;
      prev_wd = prev_rd;
    end
  end

  always_comb begin
    if (ctl.unlink_head)      val_raddr = next_rd;
    else if (ctl.unlink_tail) val_raddr = prev_rd;
    else                      val_raddr = tgt_sel;
  end

  always_ff @(posedge clk) begin
    if (ctl.do_push) val_mem[free_slot] <= word_q;
    val_rd <= val_mem[val_raddr];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (ctl.start_read) begin
      next_rd <= next_mem[tgt_sel];
      prev_rd <= prev_mem[tgt_sel];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q    <= command;
      word_q   <= data_word[SW-1:0];
      handle_q <= slot_handle;
    end
    if (ctl.start_read) tgt <= tgt_sel;
    if (ctl.status_load) begin
      status_q <= ctl.status_code;
      oword_q  <= '0;
      oslot_q  <= ctl.do_push ? free_slot : '0;
    end
    if (ctl.do_push) begin
      if (list_empty) begin
        head_val <= word_q;
        tail_val <= word_q;
      end else if (push_tail) begin
        tail_val <= word_q;
      end else begin
        head_val <= word_q;
      end
    end
    if (ctl.unlink) begin
      oword_q <= val_rd;
      oslot_q <= tgt;
    end
    if (ctl.fetch_head) head_val <= val_rd;
    if (ctl.fetch_tail) tail_val <= val_rd;
    if (ctl.emit) begin
      status      <= status_q;
      out_word    <= lde_pkg::WORD_W'(oword_q);
      out_slot    <= lde_pkg::HANDLE_W'(oslot_q);
      entry_count <= lde_pkg::COUNT_W'(count);
      head_word   <= list_empty ? '0 : lde_pkg::WORD_W'(head_val);
      tail_word   <= list_empty ? '0 : lde_pkg::WORD_W'(tail_val);
    end
  end

  // List control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      in_use    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.do_push) begin
        in_use[free_slot] <= 1'b1;
        count             <= count + CW'(1);
        if (list_empty) begin
          head <= free_slot;
          tail <= free_slot;
        end else if (push_tail) begin
          tail <= free_slot;
        end else begin
          head <= free_slot;
        end
      end
      if (ctl.do_clear) begin
        in_use <= '0;
        head   <= '0;
        tail   <= '0;
        count  <= '0;
      end
      if (ctl.unlink) begin
        in_use[tgt] <= 1'b0;
        count       <= count - CW'(1);
      end
      if (ctl.unlink_single) begin
        head <= '0;
        tail <= '0;
      end
      if (ctl.unlink_head) head <= next_rd;
      if (ctl.unlink_tail) tail <= prev_rd;
      if (ctl.emit)           rsp_valid <= 1'b1;
      else if (rsp_ready)     rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/linked_deque_engine.sv
// Top level of the linked deque engine: sequencer, datapath and checks.
`default_nettype none

`include "linked_deque_engine_assert.svh"

// A doubly linked list of data words held in a store of NODE_DEPTH slots, driven
// by one command per transfer on cmd and answered by exactly one transfer on rsp.
// Push at tail or head takes the lowest free slot and returns it in out_slot; pop
// at tail or head and remove-by-slot return the unlinked word and slot; clear
// frees every slot at once. Failed commands (pop on empty, push when full, remove
// of a free or out-of-range slot) leave the list as it was and say so in status.
// Every result carries the node count and the words at head and tail (zero when
// the list is empty). One command is in flight at a time and cmd.ready is high
// only while the block is idle. A push, clear, failed or unused command passes
// through the exec and done states only; a remove from the middle of the list or
// a pop or remove of the only node adds the link state, and a pop or a remove at
// either end of a longer list adds the fetch state too. These come from the
// registered read ports of the node store: unlinking an end node first reads its
// link, then reads the word of the new end node. The result register frees the
// sequencer as soon as it is loaded; a held result only delays the next command's
// completion, not its acceptance. Word storage is WORD_WIDTH bits (at most 32 are
// kept); node words and links have no reset and are only used for slots in use.

module linked_deque_engine #(
  parameter int NODE_DEPTH = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  lde_cmd_if.sink   cmd,
  lde_rsp_if.source rsp
);

  // Low bits of the count as reported when the store is full.
  localparam logic [lde_pkg::COUNT_W-1:0] FULL_COUNT = lde_pkg::COUNT_W'(NODE_DEPTH);

  lde_pkg::ctl_cmd_t ctl;
  lde_pkg::dp_stat_t stat;

  // Sequence each command: decide, unlink, refetch the end word, hand over.
  lde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Hold the node store, the list ends and the result register.
  lde_datapath #(
    .NODE_DEPTH (NODE_DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (cmd.command),
    .data_word   (cmd.data_word),
    .slot_handle (cmd.slot_handle),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .status      (rsp.status),
    .out_word    (rsp.out_word),
    .out_slot    (rsp.out_slot),
    .entry_count (rsp.entry_count),
    .head_word   (rsp.head_word),
    .tail_word   (rsp.tail_word)
  );

  // A full report must come with a full store.
  `LDE_ASSERT_IMP(a_full_count, rsp.valid && rsp.status == lde_pkg::ST_FULL, rsp.entry_count == FULL_COUNT)
  // An empty report carries no word and an empty count.
  `LDE_ASSERT_IMP(a_empty_word, rsp.valid && rsp.status == lde_pkg::ST_EMPTY, rsp.entry_count == '0 && rsp.out_word == '0)
  // An empty list shows zero at both ends.
  `LDE_ASSERT_IMP(a_empty_ends, rsp.valid && rsp.entry_count == '0, rsp.head_word == '0 && rsp.tail_word == '0)
  // Drop ready once a command is taken: one command in flight.
  `LDE_ASSERT_NXT(a_one_cmd, cmd.valid && cmd.ready, !cmd.ready)

endmodule

`default_nettype wire
